// ===== rtl/hpbt_pkg.sv =====
// Shared types and constants for the histogram probability table.
// Holds opcodes, register indexes, controller states and the command/status structs.
`default_nettype none
package hpbt_pkg;

   localparam int MAX_BINS_DEF = 256;

   localparam int VALUE_W  = 32;
   localparam int CSR_W    = 32;
   localparam int CSR_IDXW = 2;
   localparam int CFGBIN_W = 9;
   localparam int BINNUM_W = 9;
   localparam int PROB_W   = 25;
   localparam int ERR_W    = 2;
   localparam int REQ_DW   = 32;
   localparam int REQ_UW   = 2;
   localparam int RSP_DW   = 40;
   localparam int FRAC_W   = 24;

   // Divider: Q0.24 numerator is a 32-bit count shifted by 24
   localparam int DIV_NUM_W = 56;
   localparam int DIV_DEN_W = 32;
   localparam int DIV_CNT_W = 6;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_FINISH = 2'd1,
      OP_QUERY  = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ERR_OK        = 2'd0,
      ERR_NO_TABLE  = 2'd1,
      ERR_NO_EVENTS = 2'd2
   } err_type;

   typedef enum logic [1:0] {
      CSR_ENERGY_MIN     = 2'd0,
      CSR_BIN_SCALE      = 2'd1,
      CSR_BINS_IN_USE    = 2'd2,
      CSR_BACKFILL_START = 2'd3
   } csr_idx_type;

   typedef enum logic [1:0] {
      RD_NONE,
      RD_BIN,
      RD_IDX,
      RD_SCAN
   } rd_sel_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_ZERO,
      WR_COUNT,
      WR_NORM,
      WR_FILL
   } wr_sel_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_OFFSET,
      ST_MULT,
      ST_BIN,
      ST_WIPE,
      ST_ADD_RD,
      ST_ADD_WR,
      ST_Q_RD,
      ST_Q_DATA,
      ST_NORM_RD,
      ST_NORM_START,
      ST_NORM_DIV,
      ST_BF_INIT,
      ST_BF_RD,
      ST_BF_CHK,
      ST_BF_DIV,
      ST_BF_FILL,
      ST_FIN_DONE,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic       item_load;
      logic       off_load;
      logic       mul_load;
      logic       bin_load;
      logic       idx_clr;
      logic       idx_inc;
      logic       wipe_state;
      rd_sel_type mem_rd;
      wr_sel_type mem_wr;
      logic       prob_load;
      logic       div_start_norm;
      logic       div_start_fill;
      logic       bf_init;
      logic       run_open;
      logic       run_close;
      logic       j_inc;
      logic       fill_init;
      logic       set_ready;
      logic       rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      opcode_type op;
      logic       ready;
      logic       total_zero;
      logic       idx_last;
      logic       rd_zero;
      logic       in_run;
      logic       scan_last;
      logic       bf_skip;
      logic       div_done;
      logic       fill_last;
      logic       rsp_free;
   } dp_sts_type;

endpackage
`default_nettype wire

// ===== rtl/hpbt_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on hpbt_pkg for its widths.
`default_nettype none
module hpbt_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [hpbt_pkg::DIV_NUM_W-1:0] num,
   input  wire logic [hpbt_pkg::DIV_DEN_W-1:0] den,
   output logic                               done,
   output logic [hpbt_pkg::DIV_NUM_W-1:0]      quot
);
   import hpbt_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_DEN_W:0]   rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W:0]   rem_sh;
   logic                 ge;

   // shift one numerator bit into the remainder, subtract when it fits
   always_comb begin
      rem_sh  = {rem_ff[DIV_DEN_W-1:0], num_ff[DIV_NUM_W-1]};
      ge      = rem_sh >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         rem_in = ge ? (rem_sh - {1'b0, den_ff}) : rem_sh;
         num_in = {num_ff[DIV_NUM_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = num_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset) start |-> !busy_ff)
      else $error("divider started while busy");
   a_done_once: assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("divider done while still iterating");

endmodule
`default_nettype wire

// ===== rtl/hpbt_ctrl.sv =====
// Sequencer for add, finish and query requests and the clearing sweeps.
// Depends on hpbt_pkg; drives the datapath by dp_cmd_type only.
`default_nettype none
module hpbt_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire hpbt_pkg::dp_sts_type sts,
   output hpbt_pkg::dp_cmd_type      cmd
);
   import hpbt_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.mem_rd = RD_NONE;
      cmd.mem_wr = WR_NONE;
      req_tready = 1'b0;
      unique case (state_ff)
         // zero the bin memory once after reset
         ST_CLEAR: begin
            cmd.mem_wr  = WR_ZERO;
            cmd.idx_inc = 1'b1;
            if (sts.idx_last) begin
               cmd.idx_clr = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready    = 1'b1;
            cmd.item_load = req_tvalid;
            if (req_tvalid) state_in = ST_OFFSET;
         end
         ST_OFFSET: begin
            cmd.off_load = 1'b1;
            state_in     = ST_MULT;
         end
         ST_MULT: begin
            cmd.mul_load = 1'b1;
            state_in     = ST_BIN;
         end
         // dispatch on opcode
         ST_BIN: begin
            cmd.bin_load = 1'b1;
            cmd.idx_clr  = 1'b1;
            unique case (sts.op)
               OP_ADD:    state_in = sts.ready ? ST_WIPE : ST_ADD_RD;
               OP_QUERY:  state_in = ST_Q_RD;
               OP_FINISH: state_in = (sts.ready || sts.total_zero) ? ST_RESP : ST_NORM_RD;
               OP_NONE:   state_in = ST_RESP;
            endcase
         end
         // drop the finished table before a new add
         ST_WIPE: begin
            cmd.mem_wr     = WR_ZERO;
            cmd.idx_inc    = 1'b1;
            cmd.wipe_state = 1'b1;
            if (sts.idx_last) begin
               cmd.idx_clr = 1'b1;
               state_in    = ST_ADD_RD;
            end
         end
         ST_ADD_RD: begin
            cmd.mem_rd = RD_BIN;
            state_in   = ST_ADD_WR;
         end
         ST_ADD_WR: begin
            cmd.mem_wr = WR_COUNT;
            state_in   = ST_RESP;
         end
         ST_Q_RD: begin
            cmd.mem_rd = RD_BIN;
            state_in   = ST_Q_DATA;
         end
         ST_Q_DATA: begin
            cmd.prob_load = 1'b1;
            state_in      = ST_RESP;
         end
         // normalise every bin to Q0.24
         ST_NORM_RD: begin
            cmd.mem_rd = RD_IDX;
            state_in   = ST_NORM_START;
         end
         ST_NORM_START: begin
            cmd.div_start_norm = 1'b1;
            state_in           = ST_NORM_DIV;
         end
         ST_NORM_DIV: begin
            if (sts.div_done) begin
               cmd.mem_wr = WR_NORM;
               if (sts.idx_last) begin
                  cmd.idx_clr = 1'b1;
                  state_in    = ST_BF_INIT;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = ST_NORM_RD;
               end
            end
         end
         // walk bins s..n and spread each nonzero bin that ends an empty run over that run and itself
         ST_BF_INIT: begin
            cmd.bf_init = 1'b1;
            state_in    = sts.bf_skip ? ST_FIN_DONE : ST_BF_RD;
         end
         ST_BF_RD: begin
            cmd.mem_rd = RD_SCAN;
            state_in   = ST_BF_CHK;
         end
         ST_BF_CHK: begin
            if (!sts.rd_zero && sts.in_run) begin
               cmd.div_start_fill = 1'b1;
               state_in           = ST_BF_DIV;
            end else begin
               cmd.run_open = sts.rd_zero && !sts.in_run;
               if (sts.scan_last) begin
                  state_in = ST_FIN_DONE;
               end else begin
                  cmd.j_inc = 1'b1;
                  state_in  = ST_BF_RD;
               end
            end
         end
         ST_BF_DIV: begin
            if (sts.div_done) begin
               cmd.fill_init = 1'b1;
               state_in      = ST_BF_FILL;
            end
         end
         ST_BF_FILL: begin
            cmd.mem_wr = WR_FILL;
            if (sts.fill_last) begin
               cmd.run_close = 1'b1;
               if (sts.scan_last) begin
                  state_in = ST_FIN_DONE;
               end else begin
                  cmd.j_inc = 1'b1;
                  state_in  = ST_BF_RD;
               end
            end
         end
         ST_FIN_DONE: begin
            cmd.set_ready = 1'b1;
            state_in      = ST_RESP;
         end
         // hold until the output register is free
         ST_RESP: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/hpbt_dpath.sv =====
// Datapath: configuration registers, bin mapping, bin memory, divider and result register.
// Depends on hpbt_pkg and hpbt_div; steered by hpbt_ctrl commands.
`default_nettype none
module hpbt_dpath #(
   parameter int MAX_BINS = hpbt_pkg::MAX_BINS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_we,
   input  wire logic [hpbt_pkg::CSR_IDXW-1:0] csr_addr,
   input  wire logic [hpbt_pkg::CSR_W-1:0]  csr_wdata,
   input  wire logic [hpbt_pkg::REQ_DW-1:0] req_tdata,
   input  wire logic [hpbt_pkg::REQ_UW-1:0] req_tuser,
   input  wire hpbt_pkg::dp_cmd_type        cmd,
   output hpbt_pkg::dp_sts_type             sts,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   output logic [hpbt_pkg::RSP_DW-1:0]      rsp_tdata
);
   import hpbt_pkg::*;

   localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int NW = $clog2(MAX_BINS + 1);

   // configuration
   logic [VALUE_W-1:0]  emin_ff;
   logic [VALUE_W-1:0]  scale_ff;
   logic [CFGBIN_W-1:0] bins_ff;
   logic [CFGBIN_W-1:0] bfs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         emin_ff  <= '0;
         scale_ff <= 32'd65536;
         bins_ff  <= 9'd256;
         bfs_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_addr))
            CSR_ENERGY_MIN:     emin_ff  <= csr_wdata;
            CSR_BIN_SCALE:      scale_ff <= csr_wdata;
            CSR_BINS_IN_USE:    bins_ff  <= csr_wdata[CFGBIN_W-1:0];
            CSR_BACKFILL_START: bfs_ff   <= csr_wdata[CFGBIN_W-1:0];
         endcase
      end
   end

   // effective bin count and back-fill start
   logic [NW-1:0]       n_eff;
   logic [CFGBIN_W-1:0] bf_s;
   always_comb begin
      if (bins_ff == '0) begin
         n_eff = NW'(1);
      end else if (32'(bins_ff) > 32'(MAX_BINS)) begin
         n_eff = NW'(MAX_BINS);
      end else begin
         n_eff = NW'(bins_ff);
      end
      bf_s = (bfs_ff == '0) ? CFGBIN_W'(1) : bfs_ff;
   end

   // request, offset, product and bin
   opcode_type          op_ff;
   logic [VALUE_W-1:0]  val_ff;
   logic [VALUE_W:0]    off_ff;
   logic                neg_ff;
   logic [VALUE_W-1:0]  hi_ff;
   logic [NW-1:0]       bin_ff, bin_in;
   logic [2*VALUE_W-1:0] prod;

   assign prod = 64'(off_ff[VALUE_W-1:0]) * 64'(scale_ff);

   always_comb begin
      if (neg_ff) begin
         bin_in = NW'(1);
      end else if (hi_ff >= 32'(n_eff)) begin
         bin_in = n_eff;
      end else begin
         bin_in = NW'(hi_ff + 32'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.item_load) begin
         op_ff  <= opcode_type'(req_tuser);
         val_ff <= req_tdata;
      end
      if (cmd.off_load) begin
         off_ff <= {val_ff[VALUE_W-1], val_ff} - {emin_ff[VALUE_W-1], emin_ff};
      end
      if (cmd.mul_load) begin
         neg_ff <= off_ff[VALUE_W];
         hi_ff  <= prod[2*VALUE_W-1:VALUE_W];
      end
      if (cmd.bin_load) begin
         bin_ff <= bin_in;
      end
   end

   // sweep index, scan position, run start and fill pointer
   logic [AW-1:0] idx_ff;
   logic [NW-1:0] j_ff, run_ff, fill_ff;
   logic          in_run_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         in_run_ff <= 1'b0;
      end else begin
         if (cmd.idx_clr) begin
            idx_ff <= '0;
         end else if (cmd.idx_inc) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (cmd.bf_init || cmd.run_close) begin
            in_run_ff <= 1'b0;
         end else if (cmd.run_open) begin
            in_run_ff <= 1'b1;
         end
      end
      if (cmd.bf_init) begin
         j_ff <= NW'(bf_s);
      end else if (cmd.j_inc) begin
         j_ff <= j_ff + 1'b1;
      end
      if (cmd.run_open) begin
         run_ff <= j_ff;
      end
      if (cmd.fill_init) begin
         fill_ff <= run_ff;
      end else if (cmd.mem_wr == WR_FILL) begin
         fill_ff <= fill_ff + 1'b1;
      end
   end

   // event total and table flag
   logic [VALUE_W-1:0] total_ff;
   logic               ready_ff;

   always_ff @(posedge clock) begin
      if (reset || cmd.wipe_state) begin
         total_ff <= '0;
         ready_ff <= 1'b0;
      end else begin
         if (cmd.mem_wr == WR_COUNT && total_ff != '1) begin
            total_ff <= total_ff + 1'b1;
         end
         if (cmd.set_ready) begin
            ready_ff <= 1'b1;
         end
      end
   end

   // divider operands
   logic [DIV_NUM_W-1:0] div_num;
   logic [DIV_DEN_W-1:0] div_den;
   logic                 div_done;
   logic [DIV_NUM_W-1:0] div_quot;
   logic [VALUE_W-1:0]   rd_data_ff;
   logic [VALUE_W-1:0]   cnt_clamp;

   assign cnt_clamp = (rd_data_ff > total_ff) ? total_ff : rd_data_ff;

   always_comb begin
      if (cmd.div_start_fill) begin
         div_num = DIV_NUM_W'(rd_data_ff);
         div_den = 32'(NW'(j_ff - run_ff)) + 32'd1;
      end else begin
         div_num = {cnt_clamp, {FRAC_W{1'b0}}};
         div_den = total_ff;
      end
   end

   hpbt_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start_norm || cmd.div_start_fill),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   // bin memory: one write port, one registered read port
   logic [VALUE_W-1:0] mem [MAX_BINS];
   logic [AW-1:0]      rd_addr, wr_addr;
   logic               wr_en;
   logic [VALUE_W-1:0] wr_data;

   always_comb begin
      unique case (cmd.mem_rd)
         RD_BIN:  rd_addr = AW'(bin_ff - 1'b1);
         RD_IDX:  rd_addr = idx_ff;
         RD_SCAN: rd_addr = AW'(j_ff - 1'b1);
         RD_NONE: rd_addr = idx_ff;
      endcase
      wr_en   = 1'b1;
      wr_addr = idx_ff;
      wr_data = '0;
      unique case (cmd.mem_wr)
         WR_ZERO: begin
            wr_addr = idx_ff;
            wr_data = '0;
         end
         WR_COUNT: begin
            wr_addr = AW'(bin_ff - 1'b1);
            wr_data = (rd_data_ff == '1) ? rd_data_ff : rd_data_ff + 1'b1;
         end
         WR_NORM: begin
            wr_addr = idx_ff;
            wr_data = div_quot[VALUE_W-1:0];
         end
         WR_FILL: begin
            wr_addr = AW'(fill_ff - 1'b1);
            wr_data = div_quot[VALUE_W-1:0];
         end
         default: wr_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_rd != RD_NONE) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // query result
   logic [PROB_W-1:0] prob_ff;
   always_ff @(posedge clock) begin
      if (cmd.item_load) begin
         prob_ff <= '0;
      end else if (cmd.prob_load && ready_ff) begin
         prob_ff <= rd_data_ff[PROB_W-1:0];
      end
   end

   // result register
   logic                rsp_valid_ff;
   logic [RSP_DW-1:0]   rsp_data_ff;
   logic [BINNUM_W-1:0] rsp_bin;
   logic [PROB_W-1:0]   rsp_prob;
   err_type             rsp_err;

   always_comb begin
      rsp_bin  = '0;
      rsp_prob = '0;
      rsp_err  = ERR_OK;
      unique case (op_ff)
         OP_ADD: rsp_bin = BINNUM_W'(bin_ff);
         OP_QUERY: begin
            rsp_bin  = BINNUM_W'(bin_ff);
            rsp_prob = ready_ff ? prob_ff : '0;
            rsp_err  = ready_ff ? ERR_OK : ERR_NO_TABLE;
         end
         OP_FINISH: rsp_err = ready_ff ? ERR_OK : ERR_NO_EVENTS;
         OP_NONE: rsp_err = ERR_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_data_ff <= {3'b000, rsp_err, ready_ff, rsp_prob, rsp_bin};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // status back to the controller
   always_comb begin
      sts.op         = op_ff;
      sts.ready      = ready_ff;
      sts.total_zero = total_ff == '0;
      sts.idx_last   = idx_ff == AW'(MAX_BINS - 1);
      sts.rd_zero    = rd_data_ff == '0;
      sts.in_run     = in_run_ff;
      sts.scan_last  = j_ff == n_eff;
      sts.bf_skip    = 32'(bf_s) > 32'(n_eff);
      sts.div_done   = div_done;
      sts.fill_last  = fill_ff == j_ff;
      sts.rsp_free   = !rsp_valid_ff || rsp_tready;
   end

   a_bin_range: assert property (@(posedge clock) disable iff (reset)
      $past(cmd.bin_load) |-> (bin_ff >= NW'(1) && bin_ff <= n_eff))
      else $error("mapped bin outside 1..n");
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten before it was taken");
   a_norm_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.mem_wr == WR_NORM) |-> (div_quot <= DIV_NUM_W'(1 << FRAC_W)))
      else $error("normalised bin above one");

endmodule
`default_nettype wire

// ===== rtl/histogram_pdf_backfill_table.sv =====
// Histogram probability table: builds bin counts from event values, normalises them
// to Q0.24 with back-fill of empty bins, and answers probability queries.
//
// Channels: request (req_) carries the opcode in tuser and the Q16.16 value in tdata;
// every request gives exactly one result on rsp_. Registers are to be written on csr_
// only while the block is idle; the block itself does not enforce it.
// Timing: one request at a time. An add or a query runs offset, multiply and bin states,
// a bin read, then a count write or probability load, then the result state; the next
// request is accepted once that result is in the output register. The first add after
// a finished table first wipes all MAX_BINS bins. Unless the table is ready or holds no
// events, a finish divides each of the MAX_BINS bins on the shared bit-serial divider,
// then scans bins s..n once, with a division and a write pass for each filled run.
// Reset: a clearing pass zeroes all MAX_BINS bins of the bin memory; req_tready stays
// low until it ends.
// Stall: a result waits in the output register while rsp_tready is low; the next
// request is accepted meanwhile and its own result waits for the register to free.
// Depends on hpbt_pkg, hpbt_ctrl, hpbt_dpath, hpbt_div.
`default_nettype none
module histogram_pdf_backfill_table #(
   parameter int MAX_BINS = hpbt_pkg::MAX_BINS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request: tdata = energy_value[31:0]; tuser = opcode[1:0]
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [hpbt_pkg::REQ_DW-1:0]   req_tdata,
   input  wire logic [hpbt_pkg::REQ_UW-1:0]   req_tuser,
   // result: tdata = bin_number[8:0], probability[33:9], table_ready[34],
   //         error_code[36:35], zero fill[39:37]
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [hpbt_pkg::RSP_DW-1:0]        rsp_tdata,
   // configuration write port
   input  wire logic                          csr_we,
   input  wire logic [hpbt_pkg::CSR_IDXW-1:0] csr_addr,
   input  wire logic [hpbt_pkg::CSR_W-1:0]    csr_wdata
);
   import hpbt_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   hpbt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   hpbt_dpath #(
      .MAX_BINS (MAX_BINS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire
